// ===== design/mf3_pkg.sv =====
// shared types and constants of the 3x3 median filter
`timescale 1ns / 1ps

package mf3_pkg;

	// image limits and field widths
	localparam int MAX_WIDTH    = 1024;
	localparam int MAX_HEIGHT   = 4096;
	localparam int PIX_W        = 8;
	localparam int ROW_W        = 12;
	localparam int COL_W        = 10;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int LB_ADDR_W    = $clog2(MAX_WIDTH);
	localparam int OUT_TDATA_W  = 32;

	// register file
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 13;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

	// job queue between front and back
	localparam int QUEUE_DEPTH = 8;
	localparam int QUEUE_PTR_W = 3;
	localparam int QUEUE_CNT_W = 4;

	// one classified pixel: up to one median and one border copy
	typedef struct packed {
		logic [PIX_W-1:0] med;
		logic [PIX_W-1:0] px;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             has_med;
		logic             has_bord;
	} mf3_job_t;

endpackage

// ===== design/mf3_ram.sv =====
// generic single-clock ram, one write port and one registered read port
`timescale 1ns / 1ps

module mf3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/mf3_front.sv =====
// front part: config registers, raster counters, line buffers, window and median pipeline
`timescale 1ns / 1ps

module mf3_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [mf3_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mf3_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             pix_valid,
	output logic                             pix_ready,
	input  logic [mf3_pkg::PIX_W-1:0]        pix,
	input  logic [mf3_pkg::QUEUE_CNT_W-1:0]  queue_count,
	output logic                             push,
	output mf3_pkg::mf3_job_t                push_job
);
	import mf3_pkg::*;

	typedef logic [PIX_W-1:0] pix_t;

	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	// config registers, held clamped to 1..max
	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [WIDTH_REG_W-1:0]  cfg_w;
	logic [HEIGHT_REG_W-1:0] cfg_h;
	logic                    cfg_hit;

	always_comb begin
		cfg_w = cfg_data[WIDTH_REG_W-1:0];
		if (cfg_w == '0) begin
			cfg_w = WIDTH_REG_W'(1);
		end else if (cfg_w > WIDTH_REG_W'(MAX_WIDTH)) begin
			cfg_w = WIDTH_REG_W'(MAX_WIDTH);
		end
		cfg_h = cfg_data;
		if (cfg_h == '0) begin
			cfg_h = HEIGHT_REG_W'(1);
		end else if (cfg_h > HEIGHT_REG_W'(MAX_HEIGHT)) begin
			cfg_h = HEIGHT_REG_W'(MAX_HEIGHT);
		end
	end

	always_comb begin
		unique case (cfg_index)
			CFG_IMAGE_WIDTH:  cfg_hit = cfg_valid;
			CFG_IMAGE_HEIGHT: cfg_hit = cfg_valid;
			default:          cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_w;
				CFG_IMAGE_HEIGHT: height_q <= cfg_h;
				default: ;
			endcase
		end
	end

	// pipeline valids and credit against the queue
	logic       v_s1, v_s2, v_s3;
	logic [1:0] inflight;
	logic       accept;

	assign inflight  = 2'(v_s1) + 2'(v_s2) + 2'(v_s3);
	assign pix_ready = ((QUEUE_CNT_W+1)'(queue_count) + (QUEUE_CNT_W+1)'(inflight))
		< (QUEUE_CNT_W+1)'(QUEUE_DEPTH);
	assign accept    = pix_valid && pix_ready;

	// raster position and classification of the incoming pixel
	logic [ROW_W-1:0]        row_q;
	logic [COL_W-1:0]        col_q;
	logic [COL_W:0]          col_plus;
	logic [ROW_W:0]          row_plus;
	logic                    col_wrap, row_wrap, is_bord, is_med;

	assign col_plus = {1'b0, col_q} + 1'b1;
	assign row_plus = {1'b0, row_q} + 1'b1;
	assign col_wrap = col_plus >= width_q;
	assign row_wrap = row_plus >= height_q;
	assign is_bord  = (row_q == '0) || (col_q == '0) || row_wrap || col_wrap;
	assign is_med   = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_hit) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_plus[ROW_W-1:0];
			end else begin
				col_q <= col_plus[COL_W-1:0];
			end
		end
	end

	// line buffers: upper byte row above, lower byte two rows above
	logic [2*PIX_W-1:0] lb_rd;
	logic [PIX_W-1:0]   px_s1, px_s2, px_s3;
	logic [ROW_W-1:0]   row_s1, row_s2, row_s3;
	logic [COL_W-1:0]   col_s1, col_s2, col_s3;
	logic               med_s1, med_s2, med_s3;
	logic               bord_s1, bord_s2, bord_s3;
	logic [PIX_W-1:0]   mid_s1, top_s1;

	assign mid_s1 = lb_rd[2*PIX_W-1:PIX_W];
	assign top_s1 = lb_rd[PIX_W-1:0];

	mf3_ram #(
		.WIDTH (2*PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_buf (
		.clk     (clk),
		.wr_en   (v_s1),
		.wr_addr (col_s1[LB_ADDR_W-1:0]),
		.wr_data ({px_s1, mid_s1}),
		.rd_en   (accept),
		.rd_addr (col_q[LB_ADDR_W-1:0]),
		.rd_data (lb_rd)
	);

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		px_s1   <= pix;
		row_s1  <= row_q;
		col_s1  <= col_q;
		med_s1  <= is_med;
		bord_s1 <= is_bord;
		px_s2   <= px_s1;
		row_s2  <= row_s1;
		col_s2  <= col_s1;
		med_s2  <= med_s1;
		bord_s2 <= bord_s1;
		px_s3   <= px_s2;
		row_s3  <= row_s2;
		col_s3  <= col_s2;
		med_s3  <= med_s2;
		bord_s3 <= bord_s2;
	end

	// sort the new column and shift it into the window
	pix_t col_lo, col_md, col_hi, t_lo, t_hi;
	pix_t win_lo_q [3];
	pix_t win_md_q [3];
	pix_t win_hi_q [3];

	always_comb begin
		t_lo   = min2(top_s1, mid_s1);
		t_hi   = max2(top_s1, mid_s1);
		col_lo = min2(t_lo, px_s1);
		col_hi = max2(t_hi, px_s1);
		col_md = max2(t_lo, min2(t_hi, px_s1));
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			win_lo_q[0] <= win_lo_q[1];
			win_lo_q[1] <= win_lo_q[2];
			win_lo_q[2] <= col_lo;
			win_md_q[0] <= win_md_q[1];
			win_md_q[1] <= win_md_q[2];
			win_md_q[2] <= col_md;
			win_hi_q[0] <= win_hi_q[1];
			win_hi_q[1] <= win_hi_q[2];
			win_hi_q[2] <= col_hi;
		end
	end

	// max of minima, median of medians, min of maxima
	pix_t lo_s3, md_s3, hi_s3;

	always_ff @(posedge clk) begin
		lo_s3 <= max2(max2(win_lo_q[0], win_lo_q[1]), win_lo_q[2]);
		md_s3 <= med3(win_md_q[0], win_md_q[1], win_md_q[2]);
		hi_s3 <= min2(min2(win_hi_q[0], win_hi_q[1]), win_hi_q[2]);
	end

	// final median and hand-off to the queue
	assign push              = v_s3 && (med_s3 || bord_s3);
	assign push_job.med      = med3(lo_s3, md_s3, hi_s3);
	assign push_job.px       = px_s3;
	assign push_job.row      = row_s3;
	assign push_job.col      = col_s3;
	assign push_job.has_med  = med_s3;
	assign push_job.has_bord = bord_s3;

endmodule

// ===== design/mf3_queue.sv =====
// short job queue between the front and the back part
`timescale 1ns / 1ps

module mf3_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  mf3_pkg::mf3_job_t               push_job,
	input  logic                            pop,
	output mf3_pkg::mf3_job_t               head,
	output logic                            empty,
	output logic [mf3_pkg::QUEUE_CNT_W-1:0] count
);
	import mf3_pkg::*;

	mf3_job_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// credit in the front must keep the queue from overflowing
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < QUEUE_CNT_W'(QUEUE_DEPTH)) || pop)
		else $error("job queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue underflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty)
		else $error("job queue lost a pushed job");

endmodule

// ===== design/mf3_back.sv =====
// back part: expands a job into its results and drives the output register
`timescale 1ns / 1ps

module mf3_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mf3_pkg::mf3_job_t               head,
	input  logic                            empty,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [mf3_pkg::PIX_W-1:0]       out_value,
	output logic [mf3_pkg::ROW_W-1:0]       out_row,
	output logic [mf3_pkg::COL_W-1:0]       out_col,
	output logic                            out_last
);
	import mf3_pkg::*;

	logic             valid_q, phase_q, load, emit_med;
	logic [PIX_W-1:0] value_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             last_q;

	// median goes first, border copy second
	assign load     = !empty && (!valid_q || out_ready);
	assign emit_med = head.has_med && !phase_q;
	assign pop      = load && !(emit_med && head.has_bord);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= emit_med && head.has_bord;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// result payload, median sits one row and one column back
	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= emit_med ? head.med : head.px;
			row_q   <= emit_med ? head.row - 1'b1 : head.row;
			col_q   <= emit_med ? head.col - 1'b1 : head.col;
			last_q  <= emit_med ? !head.has_bord : 1'b1;
		end
	end

	assign out_valid = valid_q;
	assign out_value = value_q;
	assign out_row   = row_q;
	assign out_col   = col_q;
	assign out_last  = last_q;

endmodule

// ===== design/median_filter_3x3_core.sv =====
// top level of the 3x3 median filter
//
//  channel   direction  handshake                 payload
//  s_*       in         s_tvalid / s_tready       s_tdata: pixel
//  m_*       out        m_tvalid / m_tready       m_tdata: value, row, col; m_tlast
//  cfg_*     in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one pixel per cycle is taken while the job queue has room; a pixel with
// both a median and a border copy holds the output for two results.
// the line buffer is one ram read at the pixel's column and written back the
// next cycle. reset returns the counters to the frame start; the line buffer
// needs no clearing pass. output stalls fill the queue, then drop s_tready.
`timescale 1ns / 1ps

module median_filter_3x3_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [mf3_pkg::PIX_W-1:0]          s_tdata,   // [7:0] pixel
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [mf3_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [7:0] value, [19:8] row, [29:20] col
	output logic                               m_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mf3_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mf3_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mf3_pkg::*;

	mf3_job_t               push_job, head;
	logic                   push, pop, empty;
	logic [QUEUE_CNT_W-1:0] queue_count;
	logic [PIX_W-1:0]       out_value;
	logic [ROW_W-1:0]       out_row;
	logic [COL_W-1:0]       out_col;

	// registers are always writable
	assign cfg_ready = 1'b1;

	mf3_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pix_valid   (s_tvalid),
		.pix_ready   (s_tready),
		.pix         (s_tdata),
		.queue_count (queue_count),
		.push        (push),
		.push_job    (push_job)
	);

	mf3_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.count    (queue_count)
	);

	mf3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_value (out_value),
		.out_row   (out_row),
		.out_col   (out_col),
		.out_last  (m_tlast)
	);

	// pack the result fields, lowest field first
	assign m_tdata = {2'b00, out_col, out_row, out_value};

endmodule
